/* design/forth_stack_alu_core_defines.svh */
// ----------------------------------------------------------------------------
// Forth stack ALU core assertion macros
// Shared assertion forms for the checker files of the stack ALU core.
// ----------------------------------------------------------------------------
`ifndef FORTH_STACK_ALU_CORE_DEFINES_SVH
`define FORTH_STACK_ALU_CORE_DEFINES_SVH

// clocked assertion, reset held low disables it
`define FSA_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// same, on the block clock and reset
`define FSA_ASSERT(label, prop, msg) \
    `FSA_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

/* design/fsa_pkg.sv */
// ----------------------------------------------------------------------------
// Forth stack ALU core package
// Sizes, opcodes, state types and the combinational word functions.
// ----------------------------------------------------------------------------
package fsa_pkg;

    localparam int WORD_BITS    = 32;
    localparam int DATA_DEPTH   = 64;
    localparam int RETURN_DEPTH = 32;

    localparam int FUNC_BITS  = 6;
    localparam int LIT_BITS   = 32;
    localparam int OUT_BITS   = 32;
    localparam int DEPTH_BITS = 7;
    localparam int ERR_BITS   = 2;

    localparam int CNT_BITS   = $clog2(DATA_DEPTH + 1);
    localparam int DADDR_BITS = $clog2(DATA_DEPTH);
    localparam int RCNT_BITS  = $clog2(RETURN_DEPTH + 1);
    localparam int RADDR_BITS = $clog2(RETURN_DEPTH);
    localparam int SH_BITS    = $clog2(WORD_BITS);
    localparam int UCNT_BITS  = $clog2(2 * WORD_BITS + 1);

    typedef logic [WORD_BITS-1:0] t_word;

    typedef enum logic [ERR_BITS-1:0] {
        ERR_OK    = 2'd0,
        ERR_UNDER = 2'd1,
        ERR_OVER  = 2'd2,
        ERR_DIV0  = 2'd3
    } t_err;

    typedef enum logic [FUNC_BITS-1:0] {
        OP_LIT = 6'd0, OP_NOT = 6'd1, OP_AND = 6'd2, OP_OR = 6'd3, OP_XOR = 6'd4,
        OP_ADD = 6'd5, OP_SUB = 6'd6, OP_MUL = 6'd7, OP_DIV = 6'd8, OP_MOD = 6'd9,
        OP_SHIFT = 6'd10, OP_DUP = 6'd11, OP_DROP = 6'd12, OP_SWAP = 6'd13,
        OP_OVER = 6'd14, OP_ROT = 6'd15, OP_PICK = 6'd16, OP_QDUP = 6'd17,
        OP_TOR = 6'd18, OP_RFROM = 6'd19, OP_RFETCH = 6'd20, OP_DEPTH = 6'd21,
        OP_LT = 6'd22, OP_EQ = 6'd23, OP_GT = 6'd24, OP_ZLT = 6'd25, OP_ZEQ = 6'd26,
        OP_ZGT = 6'd27, OP_ULT = 6'd28, OP_INC1 = 6'd29, OP_INC2 = 6'd30,
        OP_DEC2 = 6'd31, OP_UMUL = 6'd32, OP_HALF = 6'd33, OP_MAX = 6'd34,
        OP_MIN = 6'd35, OP_ABS = 6'd36, OP_NEGATE = 6'd37, OP_ABORT = 6'd38,
        OP_DIVMOD = 6'd39, OP_INC4 = 6'd40, OP_DEC4 = 6'd41, OP_MUL4 = 6'd42,
        OP_DIV4 = 6'd43, OP_MUL2 = 6'd44, OP_STARSLASH = 6'd45, OP_ROLL = 6'd46
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_WAIT, S_RD3, S_ROT2, S_PICK, S_RPOP,
        S_ROLL_T, S_ROLL_RD, S_ROLL_WR, S_FETCH, S_SECOND, S_DONE
    } t_state;

    typedef enum logic [1:0] {
        U_IDLE, U_MUL, U_DIV, U_DONE
    } t_ustate;

    typedef enum logic [1:0] {
        UOP_MUL, UOP_DIV, UOP_MULDIV
    } t_unit_op;

    typedef struct packed {
        logic     start;
        t_unit_op op;
        t_word    a;
        t_word    b;
        t_word    c;
    } t_unit_req;

    typedef struct packed {
        logic  done;
        t_word prod;
        t_word quot;
        t_word rem;
    } t_unit_rsp;

    function automatic t_word flag(input logic t);
        return t ? {WORD_BITS{1'b1}} : '0;
    endfunction

    function automatic t_word mag(input t_word x);
        return x[WORD_BITS-1] ? t_word'(-x) : x;
    endfunction

    function automatic logic [1:0] need_of(input logic [FUNC_BITS-1:0] f);
        case (f)
            OP_NOT, OP_DUP, OP_DROP, OP_PICK, OP_QDUP, OP_TOR, OP_ZLT, OP_ZEQ,
            OP_ZGT, OP_INC1, OP_INC2, OP_DEC2, OP_HALF, OP_ABS, OP_NEGATE,
            OP_INC4, OP_DEC4, OP_MUL4, OP_DIV4, OP_MUL2, OP_ROLL: return 2'd1;
            OP_AND, OP_OR, OP_XOR, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
            OP_SHIFT, OP_SWAP, OP_OVER, OP_LT, OP_EQ, OP_GT, OP_ULT, OP_UMUL,
            OP_MAX, OP_MIN, OP_DIVMOD: return 2'd2;
            OP_ROT, OP_STARSLASH: return 2'd3;
            default: return 2'd0;
        endcase
    endfunction

    function automatic logic room_of(input logic [FUNC_BITS-1:0] f);
        case (f)
            OP_LIT, OP_DUP, OP_OVER, OP_RFROM, OP_RFETCH, OP_DEPTH: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic t_word shift_word(input t_word a, input t_word b);
        t_word m;
        m = mag(b);
        if (b[WORD_BITS-1]) begin
            if (m >= t_word'(WORD_BITS)) return {WORD_BITS{a[WORD_BITS-1]}};
            return t_word'($signed(a) >>> m[SH_BITS-1:0]);
        end
        if (b >= t_word'(WORD_BITS)) return '0;
        return a << b[SH_BITS-1:0];
    endfunction

    function automatic t_word alu1(input logic [FUNC_BITS-1:0] f, input t_word x);
        case (f)
            OP_NOT:    return ~x;
            OP_ZLT:    return flag(x[WORD_BITS-1]);
            OP_ZEQ:    return flag(x == '0);
            OP_ZGT:    return flag((x != '0) && !x[WORD_BITS-1]);
            OP_INC1:   return x + t_word'(1);
            OP_INC2:   return x + t_word'(2);
            OP_DEC2:   return x - t_word'(2);
            OP_HALF:   return t_word'($signed(x) >>> 1);
            OP_ABS:    return mag(x);
            OP_NEGATE: return t_word'(-x);
            OP_INC4:   return x + t_word'(4);
            OP_DEC4:   return x - t_word'(4);
            OP_MUL4:   return x << 2;
            OP_DIV4:   return t_word'($signed(x) >>> 2);
            OP_MUL2:   return x << 1;
            default:   return x;
        endcase
    endfunction

    function automatic t_word alu2(input logic [FUNC_BITS-1:0] f, input t_word a,
                                   input t_word b);
        case (f)
            OP_AND:   return a & b;
            OP_OR:    return a | b;
            OP_XOR:   return a ^ b;
            OP_ADD:   return a + b;
            OP_SUB:   return a - b;
            OP_SHIFT: return shift_word(a, b);
            OP_LT:    return flag($signed(a) < $signed(b));
            OP_EQ:    return flag(a == b);
            OP_GT:    return flag($signed(b) < $signed(a));
            OP_ULT:   return flag(a < b);
            OP_MAX:   return ($signed(b) < $signed(a)) ? a : b;
            OP_MIN:   return ($signed(a) < $signed(b)) ? a : b;
            default:  return b;
        endcase
    endfunction

endpackage

/* design/fsa_if.sv */
// ----------------------------------------------------------------------------
// Forth stack ALU core channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface fsa_req_if;
    logic                           valid;
    logic                           ready;
    logic [fsa_pkg::FUNC_BITS-1:0]  func;
    logic signed [fsa_pkg::LIT_BITS-1:0] literal_value;

    modport source (output valid, output func, output literal_value, input ready);
    modport sink   (input valid, input func, input literal_value, output ready);
endinterface

interface fsa_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [fsa_pkg::OUT_BITS-1:0] top_value;
    logic signed [fsa_pkg::OUT_BITS-1:0] second_value;
    logic [fsa_pkg::DEPTH_BITS-1:0]      stack_depth;
    logic [fsa_pkg::ERR_BITS-1:0]        error_code;

    modport source (output valid, output top_value, output second_value,
                    output stack_depth, output error_code, input ready);
    modport sink   (input valid, input top_value, input second_value,
                    input stack_depth, input error_code, output ready);
endinterface

/* design/fsa_unit.sv */
// ----------------------------------------------------------------------------
// Forth stack ALU shared multiply/divide unit
// Shift-add multiplier and restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
module fsa_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fsa_pkg::t_unit_req i_req,
    output fsa_pkg::t_unit_rsp o_rsp
);

    fsa_pkg::t_ustate r_state, n_state;
    fsa_pkg::t_unit_op r_op, n_op;
    logic [fsa_pkg::UCNT_BITS-1:0] r_cnt, n_cnt;
    logic [fsa_pkg::WORD_BITS:0]   r_hi, n_hi;
    fsa_pkg::t_word r_lo, n_lo;
    fsa_pkg::t_word r_mcand, n_mcand;
    fsa_pkg::t_word r_mc, n_mc;
    fsa_pkg::t_word r_rem, n_rem;
    fsa_pkg::t_word r_q, n_q;
    logic [2*fsa_pkg::WORD_BITS-1:0] r_div, n_div;
    logic r_neg_q, n_neg_q;
    logic r_neg_r, n_neg_r;

    logic [fsa_pkg::WORD_BITS:0] w_sum;
    logic [fsa_pkg::WORD_BITS:0] w_rr;
    logic                        w_ge;

    assign w_sum = r_hi + (r_lo[0] ? {1'b0, r_mcand} : '0);
    assign w_rr  = {r_rem, r_div[2*fsa_pkg::WORD_BITS-1]};
    assign w_ge  = w_rr >= {1'b0, r_mc};

    always_comb begin
        n_state = r_state;
        case (r_state)
            fsa_pkg::U_IDLE: begin
                if (i_req.start) begin
                    n_state = (i_req.op == fsa_pkg::UOP_DIV) ? fsa_pkg::U_DIV : fsa_pkg::U_MUL;
                end
            end
            fsa_pkg::U_MUL: begin
                if (r_cnt == '0) begin
                    n_state = (r_op == fsa_pkg::UOP_MULDIV) ? fsa_pkg::U_DIV : fsa_pkg::U_DONE;
                end
            end
            fsa_pkg::U_DIV: begin
                if (r_cnt == '0) n_state = fsa_pkg::U_DONE;
            end
            fsa_pkg::U_DONE:  n_state = fsa_pkg::U_IDLE;
            default:          n_state = fsa_pkg::U_IDLE;
        endcase
    end

    always_comb begin
        n_op    = r_op;
        n_cnt   = r_cnt;
        n_hi    = r_hi;
        n_lo    = r_lo;
        n_mcand = r_mcand;
        n_mc    = r_mc;
        n_rem   = r_rem;
        n_q     = r_q;
        n_div   = r_div;
        n_neg_q = r_neg_q;
        n_neg_r = r_neg_r;
        o_rsp   = '0;
        case (r_state)
            fsa_pkg::U_IDLE: begin
                if (i_req.start) begin
                    n_op  = i_req.op;
                    n_hi  = '0;
                    n_rem = '0;
                    n_q   = '0;
                    n_cnt = fsa_pkg::UCNT_BITS'(fsa_pkg::WORD_BITS);
                    case (i_req.op)
                        fsa_pkg::UOP_MUL: begin
                            n_mcand = i_req.a;
                            n_lo    = i_req.b;
                        end
                        fsa_pkg::UOP_DIV: begin
                            n_div   = {fsa_pkg::mag(i_req.a), fsa_pkg::t_word'(0)};
                            n_mc    = fsa_pkg::mag(i_req.b);
                            n_neg_q = i_req.a[fsa_pkg::WORD_BITS-1] ^ i_req.b[fsa_pkg::WORD_BITS-1];
                            n_neg_r = i_req.a[fsa_pkg::WORD_BITS-1];
                        end
                        default: begin
                            n_mcand = fsa_pkg::mag(i_req.a);
                            n_lo    = fsa_pkg::mag(i_req.b);
                            n_mc    = fsa_pkg::mag(i_req.c);
                            n_neg_q = i_req.a[fsa_pkg::WORD_BITS-1] ^ i_req.b[fsa_pkg::WORD_BITS-1]
                                      ^ i_req.c[fsa_pkg::WORD_BITS-1];
                            n_neg_r = 1'b0;
                        end
                    endcase
                end
            end
            fsa_pkg::U_MUL: begin
                if (r_cnt != '0) begin
                    n_hi  = {1'b0, w_sum[fsa_pkg::WORD_BITS:1]};
                    n_lo  = {w_sum[0], r_lo[fsa_pkg::WORD_BITS-1:1]};
                    n_cnt = r_cnt - fsa_pkg::UCNT_BITS'(1);
                end else begin
                    n_div = {r_hi[fsa_pkg::WORD_BITS-1:0], r_lo};
                    n_cnt = fsa_pkg::UCNT_BITS'(2 * fsa_pkg::WORD_BITS);
                end
            end
            fsa_pkg::U_DIV: begin
                if (r_cnt != '0) begin
                    n_rem = w_ge ? fsa_pkg::WORD_BITS'(w_rr - {1'b0, r_mc})
                                 : w_rr[fsa_pkg::WORD_BITS-1:0];
                    n_q   = {r_q[fsa_pkg::WORD_BITS-2:0], w_ge};
                    n_div = r_div << 1;
                    n_cnt = r_cnt - fsa_pkg::UCNT_BITS'(1);
                end
            end
            fsa_pkg::U_DONE: begin
                o_rsp.done = 1'b1;
                o_rsp.prod = r_lo;
                o_rsp.quot = r_neg_q ? fsa_pkg::t_word'(-r_q) : r_q;
                o_rsp.rem  = r_neg_r ? fsa_pkg::t_word'(-r_rem) : r_rem;
            end
            default: begin
                o_rsp = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fsa_pkg::U_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_op    <= n_op;
        r_cnt   <= n_cnt;
        r_hi    <= n_hi;
        r_lo    <= n_lo;
        r_mcand <= n_mcand;
        r_mc    <= n_mc;
        r_rem   <= n_rem;
        r_q     <= n_q;
        r_div   <= n_div;
        r_neg_q <= n_neg_q;
        r_neg_r <= n_neg_r;
    end

endmodule

/* design/forth_stack_alu_core.sv */
// Each request runs through S_IDLE, S_DECODE, S_FETCH, S_SECOND and S_DONE; an error
// goes from S_DECODE straight to S_DONE. Pick and the return stack reads add S_PICK or
// S_RPOP, rot adds S_RD3 and S_ROT2, multiply, divide and mod wait in S_WAIT, and
// star-slash S_RD3 and S_WAIT; roll S_ROLL_T, then S_ROLL_RD and S_ROLL_WR per item.
// Throughput: one request at a time. A result may wait while the next is taken.
// Reset: synchronous, active low; empties both stacks and zeroes the top.
// ----------------------------------------------------------------------------
// Forth stack ALU core
// Executes one integer Forth primitive per request on a cached-top data stack.
// ----------------------------------------------------------------------------
module forth_stack_alu_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    fsa_req_if.sink          i_req,
    fsa_rsp_if.source        o_rsp
);

    fsa_pkg::t_state r_state, n_state;
    logic [fsa_pkg::FUNC_BITS-1:0] r_func, n_func;
    logic [fsa_pkg::LIT_BITS-1:0]  r_lit, n_lit;
    fsa_pkg::t_word r_top, n_top;
    fsa_pkg::t_word r_second, n_second;
    fsa_pkg::t_word r_tmp, n_tmp;
    logic [fsa_pkg::CNT_BITS-1:0]   r_count, n_count;
    logic [fsa_pkg::RCNT_BITS-1:0]  r_rcount, n_rcount;
    logic [fsa_pkg::DADDR_BITS-1:0] r_ptr, n_ptr;
    fsa_pkg::t_err r_err, n_err;

    logic r_out_valid, n_out_valid;
    fsa_pkg::t_word r_out_top, n_out_top;
    fsa_pkg::t_word r_out_second, n_out_second;
    logic [fsa_pkg::CNT_BITS-1:0] r_out_depth, n_out_depth;
    fsa_pkg::t_err r_out_err, n_out_err;

    fsa_pkg::t_word r_dmem [fsa_pkg::DATA_DEPTH];
    fsa_pkg::t_word r_rmem [fsa_pkg::RETURN_DEPTH];
    fsa_pkg::t_word r_rdata;
    fsa_pkg::t_word r_rrdata;

    logic                           dm_we, dm_re;
    logic [fsa_pkg::DADDR_BITS-1:0] dm_waddr, dm_raddr;
    fsa_pkg::t_word                 dm_wdata;
    logic                           rm_we, rm_re;
    logic [fsa_pkg::RADDR_BITS-1:0] rm_waddr, rm_raddr;

    fsa_pkg::t_unit_req unit_req;
    fsa_pkg::t_unit_rsp unit_rsp;

    logic [fsa_pkg::CNT_BITS-1:0] w_cm1, w_cm2, w_cm3, w_pick;
    logic [1:0]     w_need;
    fsa_pkg::t_err  w_err;
    logic           w_roll_more;
    logic           w_load_out;

    fsa_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (unit_req),
        .o_rsp   (unit_rsp)
    );

    assign w_cm1  = r_count - fsa_pkg::CNT_BITS'(1);
    assign w_cm2  = r_count - fsa_pkg::CNT_BITS'(2);
    assign w_cm3  = r_count - fsa_pkg::CNT_BITS'(3);
    assign w_pick = w_cm2 - r_top[fsa_pkg::CNT_BITS-1:0];
    assign w_need = fsa_pkg::need_of(r_func);
    assign w_roll_more = (fsa_pkg::CNT_BITS'(r_ptr) + fsa_pkg::CNT_BITS'(1)) < r_count;
    assign w_load_out  = !r_out_valid || o_rsp.ready;

    always_comb begin
        w_err = fsa_pkg::ERR_OK;
        if (r_count < fsa_pkg::CNT_BITS'(w_need)) begin
            w_err = fsa_pkg::ERR_UNDER;
        end else if ((r_func == fsa_pkg::OP_RFROM || r_func == fsa_pkg::OP_RFETCH)
                     && r_rcount == '0) begin
            w_err = fsa_pkg::ERR_UNDER;
        end else if ((r_func == fsa_pkg::OP_PICK || r_func == fsa_pkg::OP_ROLL)
                     && (r_top[fsa_pkg::WORD_BITS-1]
                         || r_top >= fsa_pkg::t_word'(w_cm1))) begin
            w_err = fsa_pkg::ERR_UNDER;
        end else if (fsa_pkg::room_of(r_func)
                     && r_count >= fsa_pkg::CNT_BITS'(fsa_pkg::DATA_DEPTH)) begin
            w_err = fsa_pkg::ERR_OVER;
        end else if (r_func == fsa_pkg::OP_QDUP && r_top != '0
                     && r_count >= fsa_pkg::CNT_BITS'(fsa_pkg::DATA_DEPTH)) begin
            w_err = fsa_pkg::ERR_OVER;
        end else if (r_func == fsa_pkg::OP_TOR
                     && r_rcount >= fsa_pkg::RCNT_BITS'(fsa_pkg::RETURN_DEPTH)) begin
            w_err = fsa_pkg::ERR_OVER;
        end else if ((r_func == fsa_pkg::OP_DIV || r_func == fsa_pkg::OP_MOD
                      || r_func == fsa_pkg::OP_DIVMOD || r_func == fsa_pkg::OP_STARSLASH)
                     && r_top == '0) begin
            w_err = fsa_pkg::ERR_DIV0;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            fsa_pkg::S_IDLE: begin
                if (i_req.valid) n_state = fsa_pkg::S_DECODE;
            end
            fsa_pkg::S_DECODE: begin
                if (w_err != fsa_pkg::ERR_OK) begin
                    n_state = fsa_pkg::S_DONE;
                end else begin
                    case (r_func)
                        fsa_pkg::OP_MUL, fsa_pkg::OP_UMUL, fsa_pkg::OP_DIV,
                        fsa_pkg::OP_MOD, fsa_pkg::OP_DIVMOD:     n_state = fsa_pkg::S_WAIT;
                        fsa_pkg::OP_ROT, fsa_pkg::OP_STARSLASH:  n_state = fsa_pkg::S_RD3;
                        fsa_pkg::OP_PICK:                        n_state = fsa_pkg::S_PICK;
                        fsa_pkg::OP_RFROM, fsa_pkg::OP_RFETCH:   n_state = fsa_pkg::S_RPOP;
                        fsa_pkg::OP_ROLL:                        n_state = fsa_pkg::S_ROLL_T;
                        default:                                 n_state = fsa_pkg::S_FETCH;
                    endcase
                end
            end
            fsa_pkg::S_WAIT: begin
                if (unit_rsp.done) n_state = fsa_pkg::S_FETCH;
            end
            fsa_pkg::S_RD3: begin
                n_state = (r_func == fsa_pkg::OP_ROT) ? fsa_pkg::S_ROT2 : fsa_pkg::S_WAIT;
            end
            fsa_pkg::S_ROT2:    n_state = fsa_pkg::S_FETCH;
            fsa_pkg::S_PICK:    n_state = fsa_pkg::S_FETCH;
            fsa_pkg::S_RPOP:    n_state = fsa_pkg::S_FETCH;
            fsa_pkg::S_ROLL_T:  n_state = fsa_pkg::S_ROLL_RD;
            fsa_pkg::S_ROLL_RD: n_state = w_roll_more ? fsa_pkg::S_ROLL_WR : fsa_pkg::S_FETCH;
            fsa_pkg::S_ROLL_WR: n_state = fsa_pkg::S_ROLL_RD;
            fsa_pkg::S_FETCH:   n_state = fsa_pkg::S_SECOND;
            fsa_pkg::S_SECOND:  n_state = fsa_pkg::S_DONE;
            fsa_pkg::S_DONE: begin
                if (w_load_out) n_state = fsa_pkg::S_IDLE;
            end
            default: n_state = fsa_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        logic           do_push;
        fsa_pkg::t_word push_val;
        do_push      = 1'b0;
        push_val     = '0;
        n_func       = r_func;
        n_lit        = r_lit;
        n_top        = r_top;
        n_second     = r_second;
        n_tmp        = r_tmp;
        n_count      = r_count;
        n_rcount     = r_rcount;
        n_ptr        = r_ptr;
        n_err        = r_err;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_top    = r_out_top;
        n_out_second = r_out_second;
        n_out_depth  = r_out_depth;
        n_out_err    = r_out_err;
        dm_we        = 1'b0;
        dm_waddr     = '0;
        dm_wdata     = '0;
        dm_re        = 1'b0;
        dm_raddr     = '0;
        rm_we        = 1'b0;
        rm_waddr     = '0;
        rm_re        = 1'b0;
        rm_raddr     = '0;
        unit_req     = '0;
        case (r_state)
            fsa_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_func = i_req.func;
                    n_lit  = i_req.literal_value;
                end
            end
            fsa_pkg::S_DECODE: begin
                n_err = w_err;
                if (w_err == fsa_pkg::ERR_OK) begin
                    case (r_func)
                        fsa_pkg::OP_LIT: begin
                            do_push  = 1'b1;
                            push_val = fsa_pkg::t_word'(signed'(r_lit));
                        end
                        fsa_pkg::OP_DUP: begin
                            do_push  = 1'b1;
                            push_val = r_top;
                        end
                        fsa_pkg::OP_QDUP: begin
                            do_push  = r_top != '0;
                            push_val = r_top;
                        end
                        fsa_pkg::OP_OVER: begin
                            do_push  = 1'b1;
                            push_val = r_second;
                        end
                        fsa_pkg::OP_DEPTH: begin
                            do_push  = 1'b1;
                            push_val = fsa_pkg::t_word'(r_count);
                        end
                        fsa_pkg::OP_RFROM: begin
                            n_rcount = r_rcount - fsa_pkg::RCNT_BITS'(1);
                            rm_re    = 1'b1;
                            rm_raddr = fsa_pkg::RADDR_BITS'(r_rcount - fsa_pkg::RCNT_BITS'(1));
                        end
                        fsa_pkg::OP_RFETCH: begin
                            rm_re    = 1'b1;
                            rm_raddr = fsa_pkg::RADDR_BITS'(r_rcount - fsa_pkg::RCNT_BITS'(1));
                        end
                        fsa_pkg::OP_TOR: begin
                            rm_we    = 1'b1;
                            rm_waddr = r_rcount[fsa_pkg::RADDR_BITS-1:0];
                            n_rcount = r_rcount + fsa_pkg::RCNT_BITS'(1);
                            n_top    = r_second;
                            n_count  = w_cm1;
                        end
                        fsa_pkg::OP_DROP: begin
                            n_top   = r_second;
                            n_count = w_cm1;
                        end
                        fsa_pkg::OP_SWAP: begin
                            dm_we    = 1'b1;
                            dm_waddr = w_cm2[fsa_pkg::DADDR_BITS-1:0];
                            dm_wdata = r_top;
                            n_top    = r_second;
                        end
                        fsa_pkg::OP_ROT, fsa_pkg::OP_STARSLASH: begin
                            dm_re    = 1'b1;
                            dm_raddr = w_cm3[fsa_pkg::DADDR_BITS-1:0];
                        end
                        fsa_pkg::OP_PICK: begin
                            dm_re    = 1'b1;
                            dm_raddr = w_pick[fsa_pkg::DADDR_BITS-1:0];
                        end
                        fsa_pkg::OP_ROLL: begin
                            n_count  = w_cm1;
                            n_ptr    = w_pick[fsa_pkg::DADDR_BITS-1:0];
                            dm_re    = 1'b1;
                            dm_raddr = w_pick[fsa_pkg::DADDR_BITS-1:0];
                        end
                        fsa_pkg::OP_MUL, fsa_pkg::OP_UMUL: begin
                            unit_req.start = 1'b1;
                            unit_req.op    = fsa_pkg::UOP_MUL;
                            unit_req.a     = r_second;
                            unit_req.b     = r_top;
                        end
                        fsa_pkg::OP_DIV, fsa_pkg::OP_MOD, fsa_pkg::OP_DIVMOD: begin
                            unit_req.start = 1'b1;
                            unit_req.op    = fsa_pkg::UOP_DIV;
                            unit_req.a     = r_second;
                            unit_req.b     = r_top;
                        end
                        fsa_pkg::OP_ABORT: begin
                            n_top    = '0;
                            n_count  = '0;
                            n_rcount = '0;
                        end
                        fsa_pkg::OP_NOT, fsa_pkg::OP_ZLT, fsa_pkg::OP_ZEQ, fsa_pkg::OP_ZGT,
                        fsa_pkg::OP_INC1, fsa_pkg::OP_INC2, fsa_pkg::OP_DEC2, fsa_pkg::OP_HALF,
                        fsa_pkg::OP_ABS, fsa_pkg::OP_NEGATE, fsa_pkg::OP_INC4, fsa_pkg::OP_DEC4,
                        fsa_pkg::OP_MUL4, fsa_pkg::OP_DIV4, fsa_pkg::OP_MUL2: begin
                            n_top = fsa_pkg::alu1(r_func, r_top);
                        end
                        fsa_pkg::OP_AND, fsa_pkg::OP_OR, fsa_pkg::OP_XOR, fsa_pkg::OP_ADD,
                        fsa_pkg::OP_SUB, fsa_pkg::OP_SHIFT, fsa_pkg::OP_LT, fsa_pkg::OP_EQ,
                        fsa_pkg::OP_GT, fsa_pkg::OP_ULT, fsa_pkg::OP_MAX, fsa_pkg::OP_MIN: begin
                            n_top   = fsa_pkg::alu2(r_func, r_second, r_top);
                            n_count = w_cm1;
                        end
                        default: begin
                            n_top = r_top;
                        end
                    endcase
                end
            end
            fsa_pkg::S_WAIT: begin
                if (unit_rsp.done) begin
                    case (r_func)
                        fsa_pkg::OP_MUL, fsa_pkg::OP_UMUL: begin
                            n_top   = unit_rsp.prod;
                            n_count = w_cm1;
                        end
                        fsa_pkg::OP_DIV: begin
                            n_top   = unit_rsp.quot;
                            n_count = w_cm1;
                        end
                        fsa_pkg::OP_MOD: begin
                            n_top   = unit_rsp.rem;
                            n_count = w_cm1;
                        end
                        fsa_pkg::OP_DIVMOD: begin
                            dm_we    = 1'b1;
                            dm_waddr = w_cm2[fsa_pkg::DADDR_BITS-1:0];
                            dm_wdata = unit_rsp.rem;
                            n_top    = unit_rsp.quot;
                        end
                        default: begin
                            n_top   = unit_rsp.quot;
                            n_count = w_cm2;
                        end
                    endcase
                end
            end
            fsa_pkg::S_RD3: begin
                if (r_func == fsa_pkg::OP_ROT) begin
                    dm_we    = 1'b1;
                    dm_waddr = w_cm3[fsa_pkg::DADDR_BITS-1:0];
                    dm_wdata = r_second;
                    n_tmp    = r_top;
                    n_top    = r_rdata;
                end else begin
                    unit_req.start = 1'b1;
                    unit_req.op    = fsa_pkg::UOP_MULDIV;
                    unit_req.a     = r_rdata;
                    unit_req.b     = r_second;
                    unit_req.c     = r_top;
                end
            end
            fsa_pkg::S_ROT2: begin
                dm_we    = 1'b1;
                dm_waddr = w_cm2[fsa_pkg::DADDR_BITS-1:0];
                dm_wdata = r_tmp;
            end
            fsa_pkg::S_PICK: begin
                n_top = r_rdata;
            end
            fsa_pkg::S_RPOP: begin
                do_push  = 1'b1;
                push_val = r_rrdata;
            end
            fsa_pkg::S_ROLL_T: begin
                n_tmp = r_rdata;
            end
            fsa_pkg::S_ROLL_RD: begin
                if (w_roll_more) begin
                    dm_re    = 1'b1;
                    dm_raddr = r_ptr + fsa_pkg::DADDR_BITS'(1);
                end else begin
                    n_top = r_tmp;
                end
            end
            fsa_pkg::S_ROLL_WR: begin
                dm_we    = 1'b1;
                dm_waddr = r_ptr;
                dm_wdata = r_rdata;
                n_ptr    = r_ptr + fsa_pkg::DADDR_BITS'(1);
            end
            fsa_pkg::S_FETCH: begin
                dm_re    = 1'b1;
                dm_raddr = w_cm2[fsa_pkg::DADDR_BITS-1:0];
            end
            fsa_pkg::S_SECOND: begin
                if (r_count >= fsa_pkg::CNT_BITS'(2)) n_second = r_rdata;
            end
            fsa_pkg::S_DONE: begin
                if (w_load_out) begin
                    n_out_valid  = 1'b1;
                    n_out_top    = (r_count != '0) ? r_top : '0;
                    n_out_second = (r_count >= fsa_pkg::CNT_BITS'(2)) ? r_second : '0;
                    n_out_depth  = r_count;
                    n_out_err    = r_err;
                end
            end
            default: begin
                n_err = r_err;
            end
        endcase
        if (do_push) begin
            if (r_count != '0) begin
                dm_we    = 1'b1;
                dm_waddr = w_cm1[fsa_pkg::DADDR_BITS-1:0];
                dm_wdata = r_top;
            end
            n_top   = push_val;
            n_count = r_count + fsa_pkg::CNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fsa_pkg::S_IDLE;
            r_top       <= '0;
            r_count     <= '0;
            r_rcount    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_top       <= n_top;
            r_count     <= n_count;
            r_rcount    <= n_rcount;
            r_out_valid <= n_out_valid;
        end
        r_func       <= n_func;
        r_lit        <= n_lit;
        r_second     <= n_second;
        r_tmp        <= n_tmp;
        r_ptr        <= n_ptr;
        r_err        <= n_err;
        r_out_top    <= n_out_top;
        r_out_second <= n_out_second;
        r_out_depth  <= n_out_depth;
        r_out_err    <= n_out_err;
    end

    always_ff @(posedge i_clk) begin
        if (dm_we) r_dmem[dm_waddr] <= dm_wdata;
        if (dm_re) r_rdata <= r_dmem[dm_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (rm_we) r_rmem[rm_waddr] <= r_top;
        if (rm_re) r_rrdata <= r_rmem[rm_raddr];
    end

    assign i_req.ready        = (r_state == fsa_pkg::S_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.top_value    = fsa_pkg::OUT_BITS'(r_out_top);
    assign o_rsp.second_value = fsa_pkg::OUT_BITS'(r_out_second);
    assign o_rsp.stack_depth  = fsa_pkg::DEPTH_BITS'(r_out_depth);
    assign o_rsp.error_code   = r_out_err;

endmodule

/* design/fsa_checker.sv */
// ----------------------------------------------------------------------------
// Forth stack ALU core port checker
// Port-level properties of the core, attached by bind.
// ----------------------------------------------------------------------------
`include "forth_stack_alu_core_defines.svh"

module fsa_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               i_in_ready,
    input logic                               i_out_valid,
    input logic [fsa_pkg::OUT_BITS-1:0]       i_top,
    input logic [fsa_pkg::OUT_BITS-1:0]       i_second,
    input logic [fsa_pkg::DEPTH_BITS-1:0]     i_depth
);

    // hold off new requests while one is in flight
    `FSA_ASSERT(a_busy_after_accept, (i_in_valid && i_in_ready) |=> !i_in_ready, "ready after accept")
    // a fresh result frees the request side
    `FSA_ASSERT(a_ready_on_result, $rose(i_out_valid) |-> i_in_ready, "result without ready")
    `FSA_ASSERT(a_empty_zero, (i_out_valid && i_depth == '0) |-> (i_top == '0 && i_second == '0), "empty stack shows data")
    `FSA_ASSERT(a_single_zero, (i_out_valid && i_depth == 7'd1) |-> i_second == '0, "second shown on one item")

endmodule

bind forth_stack_alu_core fsa_checker u_fsa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_top       (o_rsp.top_value),
    .i_second    (o_rsp.second_value),
    .i_depth     (o_rsp.stack_depth)
);
